/* hdl/qeq_pkg.sv */
package qeq_pkg;

  localparam int LEVELS = 18;
  localparam int LVL_W  = 5;

  localparam int IN_W   = 16;
  localparam int PROD_W = 32;
  localparam int OP_W   = 35;
  localparam int S_W    = 30;
  localparam int RAD_W  = 57;
  localparam int RES_W  = 58;
  localparam int C_W    = 29;
  localparam int XW     = 38;
  localparam int ANG_W  = 34;

  localparam int SQRT_N   = 29;
  localparam int CORDIC_N = 30;
  localparam int FRONT_LAT  = 4;
  localparam int CORDIC_LAT = CORDIC_N + 1;
  localparam int TOTAL_LAT  = FRONT_LAT + SQRT_N + CORDIC_LAT + 1;

  localparam logic signed [OP_W-1:0]  Q28_ONE = OP_W'(64'sd268435456);
  localparam logic [RAD_W-1:0]        Q56_ONE = RAD_W'(1) << 56;
  localparam logic signed [ANG_W-1:0] ANG_PI  = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] ANG_HPI = ANG_W'(64'sd1073741824);

  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_N] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10680350, 34'sd5340245, 34'sd2670675, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
    34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
    34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  typedef struct packed {
    logic signed [OP_W-1:0] roll_num;
    logic signed [OP_W-1:0] roll_den;
    logic signed [OP_W-1:0] yaw_num;
    logic signed [OP_W-1:0] yaw_den;
    logic signed [OP_W-1:0] s;
  } ops_t;

  // clamp angle, scale to levels, saturate
  function automatic logic [LVL_W-1:0] quant_level(input logic signed [ANG_W-1:0] a,
                                                   input logic pitch);
    logic signed [ANG_W-1:0] half;
    logic signed [ANG_W-1:0] ac;
    logic [ANG_W-1:0]        off;
    logic [ANG_W+7:0]        prod;
    logic [ANG_W+7:0]        lvl;
    half = pitch ? ANG_HPI : ANG_PI;
    ac = a;
    if (a > half) ac = half;
    if (a < -half) ac = -half;
    off  = ac + half;
    prod = (ANG_W+8)'(off) * (ANG_W+8)'(LEVELS);
    lvl  = pitch ? (prod >> 31) : (prod >> 32);
    if (lvl > (ANG_W+8)'(LEVELS)) lvl = (ANG_W+8)'(LEVELS);
    return lvl[LVL_W-1:0];
  endfunction

endpackage

/* hdl/quaternion_euler_quantizer_top.sv */
// an accepted input word passes the front end, square root, cordic and level registers
// throughput: one word per cycle while the output is not stalled, set by the fully
// pipelined multipliers, the 29-stage square root and the three 31-stage cordic units
// reset clears only the valid bits; the datapath registers are not reset
// the pipeline advances whenever the output register is empty or taken
module quaternion_euler_quantizer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [qeq_pkg::IN_W-1:0]   quat_w_i,
  input  logic signed [qeq_pkg::IN_W-1:0]   quat_x_i,
  input  logic signed [qeq_pkg::IN_W-1:0]   quat_y_i,
  input  logic signed [qeq_pkg::IN_W-1:0]   quat_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [qeq_pkg::LVL_W-1:0]         roll_level_o,
  output logic [qeq_pkg::LVL_W-1:0]         pitch_level_o,
  output logic [qeq_pkg::LVL_W-1:0]         yaw_level_o
);

  localparam int L = qeq_pkg::TOTAL_LAT;

  logic                               en;
  logic [L-1:0]                       vld_q;
  logic [qeq_pkg::RAD_W-1:0]          rad;
  qeq_pkg::ops_t                      ops_f, ops_r;
  logic [qeq_pkg::C_W-1:0]            root;
  logic signed [qeq_pkg::ANG_W-1:0]   roll_ang, pitch_ang, yaw_ang;
  logic [qeq_pkg::LVL_W-1:0]          roll_q, pitch_q, yaw_q;

  assign en = !(vld_q[L-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  qeq_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .rad_o    (rad),
    .ops_o    (ops_f)
  );

  qeq_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad),
    .ops_i  (ops_f),
    .root_o (root),
    .ops_o  (ops_r)
  );

  qeq_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (ops_r.roll_num),
    .x_i   (ops_r.roll_den),
    .ang_o (roll_ang)
  );

  qeq_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (ops_r.s),
    .x_i   ({{(qeq_pkg::OP_W-qeq_pkg::C_W){1'b0}}, root}),
    .ang_o (pitch_ang)
  );

  qeq_cordic u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (ops_r.yaw_num),
    .x_i   (ops_r.yaw_den),
    .ang_o (yaw_ang)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= qeq_pkg::quant_level(roll_ang, 1'b0);
      pitch_q <= qeq_pkg::quant_level(pitch_ang, 1'b1);
      yaw_q   <= qeq_pkg::quant_level(yaw_ang, 1'b0);
    end
  end

  assign out_valid_o   = vld_q[L-1];
  assign roll_level_o  = roll_q;
  assign pitch_level_o = pitch_q;
  assign yaw_level_o   = yaw_q;

endmodule

/* hdl/qeq_front.sv */
module qeq_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [qeq_pkg::IN_W-1:0]     quat_w_i,
  input  logic signed [qeq_pkg::IN_W-1:0]     quat_x_i,
  input  logic signed [qeq_pkg::IN_W-1:0]     quat_y_i,
  input  logic signed [qeq_pkg::IN_W-1:0]     quat_z_i,
  output logic [qeq_pkg::RAD_W-1:0]           rad_o,
  output qeq_pkg::ops_t                       ops_o
);

  logic signed [qeq_pkg::PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  qeq_pkg::ops_t ops_d, ops2_q, ops3_q, ops4_q;
  logic signed [qeq_pkg::S_W-1:0]    s30;
  logic signed [2*qeq_pkg::S_W-1:0]  s2_full;
  logic [qeq_pkg::RAD_W-1:0]         s2_q, rad_q;
  logic signed [qeq_pkg::OP_W-1:0]   s_raw;

  always_comb begin
    ops_d.roll_num = 2 * (qeq_pkg::OP_W'(wx_q) + qeq_pkg::OP_W'(yz_q));
    ops_d.roll_den = qeq_pkg::Q28_ONE - 2 * (qeq_pkg::OP_W'(xx_q) + qeq_pkg::OP_W'(yy_q));
    ops_d.yaw_num  = 2 * (qeq_pkg::OP_W'(wz_q) + qeq_pkg::OP_W'(xy_q));
    ops_d.yaw_den  = qeq_pkg::Q28_ONE - 2 * (qeq_pkg::OP_W'(yy_q) + qeq_pkg::OP_W'(zz_q));
    s_raw = 2 * (qeq_pkg::OP_W'(wy_q) - qeq_pkg::OP_W'(zx_q));
    ops_d.s = s_raw;
    if (s_raw > qeq_pkg::Q28_ONE) ops_d.s = qeq_pkg::Q28_ONE;
    if (s_raw < -qeq_pkg::Q28_ONE) ops_d.s = -qeq_pkg::Q28_ONE;
  end

  assign s30     = ops2_q.s[qeq_pkg::S_W-1:0];
  assign s2_full = s30 * s30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      ops2_q <= ops_d;
      s2_q   <= s2_full[qeq_pkg::RAD_W-1:0];
      ops3_q <= ops2_q;
      rad_q  <= qeq_pkg::Q56_ONE - s2_q;
      ops4_q <= ops3_q;
    end
  end

  assign rad_o = rad_q;
  assign ops_o = ops4_q;

endmodule

/* hdl/qeq_isqrt.sv */
module qeq_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [qeq_pkg::RAD_W-1:0]  rad_i,
  input  qeq_pkg::ops_t              ops_i,
  output logic [qeq_pkg::C_W-1:0]    root_o,
  output qeq_pkg::ops_t              ops_o
);

  logic [qeq_pkg::RAD_W-1:0] v_q   [qeq_pkg::SQRT_N];
  logic [qeq_pkg::RES_W-1:0] res_q [qeq_pkg::SQRT_N];
  qeq_pkg::ops_t             ops_q [qeq_pkg::SQRT_N];

  // one result bit per stage, trial bit 4^(28-k)
  for (genvar k = 0; k < qeq_pkg::SQRT_N; k++) begin : g_stage
    localparam logic [qeq_pkg::RES_W-1:0] BIT = qeq_pkg::RES_W'(1) << (56 - 2 * k);
    logic [qeq_pkg::RAD_W-1:0] v_in;
    logic [qeq_pkg::RES_W-1:0] r_in, trial;
    qeq_pkg::ops_t             o_in;
    if (k == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
      assign o_in = ops_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = res_q[k-1];
      assign o_in = ops_q[k-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ops_q[k] <= o_in;
        if ({1'b0, v_in} >= trial) begin
          v_q[k]   <= v_in - trial[qeq_pkg::RAD_W-1:0];
          res_q[k] <= (r_in >> 1) + BIT;
        end else begin
          v_q[k]   <= v_in;
          res_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[qeq_pkg::SQRT_N-1][qeq_pkg::C_W-1:0];
  assign ops_o  = ops_q[qeq_pkg::SQRT_N-1];

endmodule

/* hdl/qeq_cordic.sv */
module qeq_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [qeq_pkg::OP_W-1:0]    y_i,
  input  logic signed [qeq_pkg::OP_W-1:0]    x_i,
  output logic signed [qeq_pkg::ANG_W-1:0]   ang_o
);

  localparam int N = qeq_pkg::CORDIC_N;

  logic signed [qeq_pkg::XW-1:0]    x_q  [N+1];
  logic signed [qeq_pkg::XW-1:0]    y_q  [N+1];
  logic signed [qeq_pkg::ANG_W-1:0] z_q  [N+1];
  logic                             sp_q [N+1];
  logic signed [qeq_pkg::ANG_W-1:0] spv_q[N+1];

  logic signed [qeq_pkg::XW-1:0] xe, ye;
  assign xe = qeq_pkg::XW'(x_i);
  assign ye = qeq_pkg::XW'(y_i);

  // axis cases give exact angles, left half plane is turned by pi first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q[0]  <= (ye == '0) || (xe == '0);
      spv_q[0] <= (ye == '0) ? ((xe < 0) ? qeq_pkg::ANG_PI : '0)
                             : ((ye > 0) ? qeq_pkg::ANG_HPI : -qeq_pkg::ANG_HPI);
      if (xe < 0) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= (ye >= 0) ? qeq_pkg::ANG_PI : -qeq_pkg::ANG_PI;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [qeq_pkg::XW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sp_q[i+1]  <= sp_q[i];
        spv_q[i+1] <= spv_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + qeq_pkg::ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - qeq_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign ang_o = sp_q[N] ? spv_q[N] : z_q[N];

endmodule

/* hdl/qeq_checker.sv */
module qeq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [qeq_pkg::LVL_W-1:0]   roll_level_o,
  input logic [qeq_pkg::LVL_W-1:0]   pitch_level_o,
  input logic [qeq_pkg::LVL_W-1:0]   yaw_level_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(roll_level_o) && $stable(pitch_level_o)
      && $stable(yaw_level_o))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> roll_level_o <= qeq_pkg::LVL_W'(qeq_pkg::LEVELS)
      && pitch_level_o <= qeq_pkg::LVL_W'(qeq_pkg::LEVELS)
      && yaw_level_o <= qeq_pkg::LVL_W'(qeq_pkg::LEVELS))
    else $error("level above saturation limit");

endmodule

bind quaternion_euler_quantizer_top qeq_checker u_qeq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .roll_level_o  (roll_level_o),
  .pitch_level_o (pitch_level_o),
  .yaw_level_o   (yaw_level_o)
);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qeq_pkg::*;

  localparam longint PI_A   = 64'sd2147483648;
  localparam longint HPI_A  = 64'sd1073741824;
  localparam longint Q28    = 64'sd268435456;
  localparam int     N_RAND = 750;

  typedef struct {
    logic [LVL_W-1:0] roll;
    logic [LVL_W-1:0] pitch;
    logic [LVL_W-1:0] yaw;
  } levels_t;

  typedef struct {
    logic signed [IN_W-1:0] w, x, y, z;
    logic                   fixed;  // expected levels typed in below
    levels_t                lv;
  } quat_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [IN_W-1:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LVL_W-1:0] roll_level_o, pitch_level_o, yaw_level_o;

  levels_t pending_levels[$];
  int      n_errors = 0;
  int      stall_left = 0;

  always #1 clk_i = ~clk_i;

  quaternion_euler_quantizer_top i_dut (.*);

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint a, xs, ys;
    a = 0;
    if (y == 0) return (x < 0) ? PI_A : 0;
    if (x == 0) return (y > 0) ? HPI_A : -HPI_A;
    if (x < 0) begin
      a = (y >= 0) ? PI_A : -PI_A;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; a += longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; a -= longint'(ATAN_TAB[i]);
      end
    end
    return a;
  endfunction

  function automatic logic [LVL_W-1:0] level_of(longint a, longint half, int sh);
    longint unsigned lvl;
    if (a > half) a = half;
    if (a < -half) a = -half;
    lvl = (longint'(a + half) * LEVELS) >> sh;
    if (lvl > LEVELS) lvl = LEVELS;
    return lvl[LVL_W-1:0];
  endfunction

  function automatic levels_t euler_levels(longint w, longint x, longint y, longint z);
    levels_t r;
    longint s, c;
    s = 2 * (w * y - z * x);
    if (s > Q28) s = Q28;
    if (s < -Q28) s = -Q28;
    c = int_sqrt(longint'(Q28 * Q28 - s * s));
    r.roll  = level_of(angle_of(2 * (w * x + y * z), Q28 - 2 * (x * x + y * y)), PI_A, 32);
    r.pitch = level_of(angle_of(s, c), HPI_A, 31);
    r.yaw   = level_of(angle_of(2 * (w * z + x * y), Q28 - 2 * (y * y + z * z)), PI_A, 32);
    return r;
  endfunction

  task automatic send_quat(quat_row_t q);
    levels_t e;
    e = q.fixed ? q.lv : euler_levels(q.w, q.x, q.y, q.z);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i <= q.w; quat_x_i <= q.x; quat_y_i <= q.y; quat_z_i <= q.z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_levels.push_back(e);
  endtask

  function automatic logic signed [IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom());
      1: return IN_W'(-16384);
      2: return IN_W'(16384);
      default: return IN_W'($signed(32'($urandom_range(0, 32768))) - 16384);
    endcase
  endfunction

  // output side: random stalls, compare in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected word roll=%0d pitch=%0d yaw=%0d",
                 roll_level_o, pitch_level_o, yaw_level_o);
          n_errors++;
        end else begin
          levels_t e;
          e = pending_levels.pop_front();
          if (roll_level_o !== e.roll) begin
            $error("roll_level expected %0d got %0d", e.roll, roll_level_o); n_errors++;
          end
          if (pitch_level_o !== e.pitch) begin
            $error("pitch_level expected %0d got %0d", e.pitch, pitch_level_o); n_errors++;
          end
          if (yaw_level_o !== e.yaw) begin
            $error("yaw_level expected %0d got %0d", e.yaw, yaw_level_o); n_errors++;
          end
        end
      end
      // mostly short stalls, now and then a long one
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        case ($urandom_range(0, 39))
          0:          begin
            stall_left = $urandom_range(5, 40);
            out_stall_i <= 1'b1;
          end
          1, 2, 3, 4, 5, 6: out_stall_i <= 1'b1;
          7:          out_stall_i <= ($urandom_range(0, 1) == 0);
          default:    out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    quat_row_t rows[$];
    quat_row_t q;
    real ang;
    rows = '{
      // identity: all angles zero, levels at mid scale
      '{16384, 0, 0, 0, 1'b1, '{9, 9, 9}},
      '{0, 0, 0, 0, 1'b1, '{9, 9, 9}},
      // roll or yaw of pi: zero y with negative x gives plus pi
      '{0, 16384, 0, 0, 1'b1, '{18, 9, 9}},
      '{0, 0, 0, 16384, 1'b1, '{9, 9, 18}},
      // pitch at and near the clamp limits, then other edge cases with levels from the bench
      '{11585, 0, 11585, 0, 1'b0, '{0, 0, 0}},
      '{16384, 0, 16384, 0, 1'b0, '{0, 0, 0}},
      '{16384, 0, -16384, 0, 1'b0, '{0, 0, 0}},
      '{-16384, -16384, -16384, -16384, 1'b0, '{0, 0, 0}},
      '{16384, 16384, 16384, 16384, 1'b0, '{0, 0, 0}},
      '{-32768, -32768, -32768, -32768, 1'b0, '{0, 0, 0}},
      '{32767, 32767, 32767, 32767, 1'b0, '{0, 0, 0}},
      '{32767, -32768, 32767, -32768, 1'b0, '{0, 0, 0}},
      '{0, 0, 16384, 0, 1'b0, '{0, 0, 0}},
      '{11585, 11585, 0, 0, 1'b0, '{0, 0, 0}},
      '{11585, -11585, 0, 0, 1'b0, '{0, 0, 0}},
      '{11585, 0, 0, 11585, 1'b0, '{0, 0, 0}},
      '{11585, 0, 0, -11585, 1'b0, '{0, 0, 0}},
      '{-1, 1, -1, 1, 1'b0, '{0, 0, 0}},
      '{8192, 8192, 8192, 8192, 1'b0, '{0, 0, 0}},
      '{8192, -8192, 8192, -8192, 1'b0, '{0, 0, 0}}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_quat(rows[i]);
    for (int n = 0; n < N_RAND; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        // quaternion built from a random angle, with random y and z
        ang = $urandom_range(0, 62831) / 10000.0;
        q.w = IN_W'($rtoi(16384.0 * $cos(ang / 2.0)));
        q.x = IN_W'($rtoi(16384.0 * $sin(ang / 2.0) * ($urandom_range(0, 100) / 100.0)));
        q.y = IN_W'($signed(32'($urandom_range(0, 16384))) - 8192);
        q.z = IN_W'($signed(32'($urandom_range(0, 16384))) - 8192);
        if ($urandom_range(0, 1)) q.x = -q.x;
        if ($urandom_range(0, 1)) q.w = -q.w;
      end else begin
        q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
      end
      q.fixed = 1'b0;
      send_quat(q);
    end
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
